// ----- hw/rtl/dfsm_pkg.sv -----
// Shared widths, register indexes, trip reason codes and helpers for the drive fault stall monitor.
package dfsm_pkg;

    // Field widths
    localparam int TIME_W  = 48;
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int STALL_W = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    // Signed speed times unsigned gain, and the doubled encoder side
    localparam int PROD_W = SPEED_W + GAIN_W + 1;
    localparam int CMP_W  = PROD_W + 1;

    // Register reset values
    localparam logic [GAIN_W-1:0]  ENC_GAIN_RST   = GAIN_W'(256);
    localparam logic [GAIN_W-1:0]  CMD_GAIN_RST   = GAIN_W'(256);
    localparam logic [STALL_W-1:0] STALL_TIME_RST = STALL_W'(1000000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_GAIN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIME = CFG_IDX_W'(2);

    // Trip reason codes
    typedef enum logic [2:0] {
        REASON_NONE    = 3'd0,
        REASON_CTRL    = 3'd1,
        REASON_BUTTON  = 3'd2,
        REASON_ENCODER = 3'd3,
        REASON_PROX    = 3'd4,
        REASON_ACCEL   = 3'd5,
        REASON_LSTALL  = 3'd6,
        REASON_RSTALL  = 3'd7
    } reason_t;

    // Item after the multiply stage
    typedef struct packed {
        logic              active;
        logic              press;
        logic              ctrl;
        logic              enc_err;
        logic              prox;
        logic              accel;
        logic [CMP_W-1:0]  e_left;
        logic [CMP_W-1:0]  c_left;
        logic [CMP_W-1:0]  e_right;
        logic [CMP_W-1:0]  c_right;
        logic [TIME_W-1:0] now;
    } scaled_t;

    // Signed speed times unsigned gain, full precision
    function automatic logic [PROD_W-1:0] scale(logic [SPEED_W-1:0] spd,
                                                logic [GAIN_W-1:0] gain);
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] g;
        a = $signed({{(PROD_W-SPEED_W){spd[SPEED_W-1]}}, spd});
        g = $signed({{(PROD_W-GAIN_W){1'b0}}, gain});
        return PROD_W'(a * g);
    endfunction

    // Encoder lags command: below it on the command's side of zero
    function automatic logic lagging(logic [CMP_W-1:0] e, logic [CMP_W-1:0] c);
        logic lag;
        if (c[CMP_W-1] == 1'b0)
            lag = $signed(e) < $signed(c);
        else
            lag = $signed(e) > $signed(c);
        return lag;
    endfunction

endpackage

// ----- hw/rtl/drive_fault_stall_monitor_top.sv -----
// Emergency-stop monitor for a two-wheel drive: arming, ordered fault checks, stall timers.
//
//  channel | signals                                   | dir | moves
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, sample fields         | in  | one sensor sample item
//  out     | out_valid, out_ready, stopped/trip/reason | out | one status item per sample
//  cfg     | cfg_we, cfg_index, cfg_data               | in  | register write, no wait
//
// One item per cycle sustained while the output is not stalled. An item passes the input
// register, the multiply register (four 16x16 gain scalings), then the check and state
// update that writes the result register. The monitor state is updated in that last
// stage alone, so consecutive items follow without gaps. Reset clears control and
// monitor state and loads the register defaults. A stalled output holds the pipeline;
// ready runs back through the stages so every register fills before input is refused.
module drive_fault_stall_monitor_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [dfsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dfsm_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                drive_active,
    input  logic                                button_press,
    input  logic                                ctrl_disabled,
    input  logic                                encoder_error,
    input  logic                                front_obstacle,
    input  logic                                rear_obstacle,
    input  logic                                accel_alert,
    input  logic signed [dfsm_pkg::SPEED_W-1:0] left_enc_speed,
    input  logic signed [dfsm_pkg::SPEED_W-1:0] right_enc_speed,
    input  logic signed [dfsm_pkg::SPEED_W-1:0] left_cmd_speed,
    input  logic signed [dfsm_pkg::SPEED_W-1:0] right_cmd_speed,
    input  logic [dfsm_pkg::TIME_W-1:0]         now_us,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                stopped,
    output logic                                trip,
    output logic [2:0]                          reason
);

    // Configuration registers
    logic [dfsm_pkg::GAIN_W-1:0]  enc_gain_reg;
    logic [dfsm_pkg::GAIN_W-1:0]  cmd_gain_reg;
    logic [dfsm_pkg::STALL_W-1:0] stall_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_gain_reg   <= dfsm_pkg::ENC_GAIN_RST;
            cmd_gain_reg   <= dfsm_pkg::CMD_GAIN_RST;
            stall_time_reg <= dfsm_pkg::STALL_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dfsm_pkg::CFG_ENC_GAIN:   enc_gain_reg   <= cfg_data[dfsm_pkg::GAIN_W-1:0];
                dfsm_pkg::CFG_CMD_GAIN:   cmd_gain_reg   <= cfg_data[dfsm_pkg::GAIN_W-1:0];
                dfsm_pkg::CFG_STALL_TIME: stall_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_free;
    logic s1_free;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: input register
    logic                        s1_active_reg;
    logic                        s1_press_reg;
    logic                        s1_ctrl_reg;
    logic                        s1_enc_err_reg;
    logic                        s1_prox_reg;
    logic                        s1_accel_reg;
    logic [dfsm_pkg::SPEED_W-1:0] s1_le_reg;
    logic [dfsm_pkg::SPEED_W-1:0] s1_re_reg;
    logic [dfsm_pkg::SPEED_W-1:0] s1_lc_reg;
    logic [dfsm_pkg::SPEED_W-1:0] s1_rc_reg;
    logic [dfsm_pkg::TIME_W-1:0]  s1_now_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            s1_active_reg  <= drive_active;
            s1_press_reg   <= button_press;
            s1_ctrl_reg    <= ctrl_disabled;
            s1_enc_err_reg <= encoder_error;
            s1_prox_reg    <= front_obstacle | rear_obstacle;
            s1_accel_reg   <= accel_alert;
            s1_le_reg      <= left_enc_speed;
            s1_re_reg      <= right_enc_speed;
            s1_lc_reg      <= left_cmd_speed;
            s1_rc_reg      <= right_cmd_speed;
            s1_now_reg     <= now_us;
        end
    end

    // Stage 2: gain scaling; encoder side doubled for the half-command test
    dfsm_pkg::scaled_t s2_next;
    dfsm_pkg::scaled_t s2_reg;

    always_comb
    begin
        s2_next.active  = s1_active_reg;
        s2_next.press   = s1_press_reg;
        s2_next.ctrl    = s1_ctrl_reg;
        s2_next.enc_err = s1_enc_err_reg;
        s2_next.prox    = s1_prox_reg;
        s2_next.accel   = s1_accel_reg;
        s2_next.e_left  = {dfsm_pkg::scale(s1_le_reg, enc_gain_reg), 1'b0};
        s2_next.e_right = {dfsm_pkg::scale(s1_re_reg, enc_gain_reg), 1'b0};
        s2_next.c_left  = dfsm_pkg::CMP_W'($signed(dfsm_pkg::scale(s1_lc_reg, cmd_gain_reg)));
        s2_next.c_right = dfsm_pkg::CMP_W'($signed(dfsm_pkg::scale(s1_rc_reg, cmd_gain_reg)));
        s2_next.now     = s1_now_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
            s2_reg <= s2_next;
    end

    // Stage 3: monitor state and ordered checks
    logic                        armed_reg, armed_next;
    logic                        prev_active_reg;
    logic                        latch_reg, latch_next;
    logic [1:0]                  run_reg, run_next;
    logic [dfsm_pkg::TIME_W-1:0] start_reg [2];
    logic [dfsm_pkg::TIME_W-1:0] start_next [2];
    logic                        lag_l, lag_r;
    logic                        stall_l, stall_r;
    logic [dfsm_pkg::TIME_W-1:0] el_l, el_r;
    logic                        armed_a;
    dfsm_pkg::reason_t           reason_next;
    logic                        stopped_next;
    logic                        advance;

    assign advance = s2_valid_reg && out_free;

    always_comb
    begin
        lag_l = dfsm_pkg::lagging(s2_reg.e_left, s2_reg.c_left);
        lag_r = dfsm_pkg::lagging(s2_reg.e_right, s2_reg.c_right);
        el_l  = s2_reg.now - start_reg[0];
        el_r  = s2_reg.now - start_reg[1];
        // a timer started this tick has zero elapsed time and cannot trip
        stall_l = lag_l && run_reg[0]
                  && (el_l > {{(dfsm_pkg::TIME_W-dfsm_pkg::STALL_W){1'b0}}, stall_time_reg});
        stall_r = lag_r && run_reg[1]
                  && (el_r > {{(dfsm_pkg::TIME_W-dfsm_pkg::STALL_W){1'b0}}, stall_time_reg});

        armed_a = s2_reg.active && (armed_reg || !prev_active_reg);

        latch_next    = 1'b0;
        run_next      = 2'b00;
        start_next[0] = start_reg[0];
        start_next[1] = start_reg[1];
        reason_next   = dfsm_pkg::REASON_NONE;

        if (armed_a)
        begin
            latch_next = latch_reg | s2_reg.press;
            priority if (s2_reg.ctrl)
                reason_next = dfsm_pkg::REASON_CTRL;
            else if (latch_next)
                reason_next = dfsm_pkg::REASON_BUTTON;
            else if (s2_reg.enc_err)
                reason_next = dfsm_pkg::REASON_ENCODER;
            else if (s2_reg.prox)
                reason_next = dfsm_pkg::REASON_PROX;
            else if (s2_reg.accel)
                reason_next = dfsm_pkg::REASON_ACCEL;
            else if (stall_l)
                reason_next = dfsm_pkg::REASON_LSTALL;
            else if (stall_r)
                reason_next = dfsm_pkg::REASON_RSTALL;
            else
                reason_next = dfsm_pkg::REASON_NONE;

            // timers survive only a tick with no trip
            if (reason_next == dfsm_pkg::REASON_NONE)
            begin
                run_next = {lag_r, lag_l};
                if (lag_l && !run_reg[0])
                    start_next[0] = s2_reg.now;
                if (lag_r && !run_reg[1])
                    start_next[1] = s2_reg.now;
            end
            else
            begin
                latch_next = 1'b0;
            end
        end

        armed_next   = armed_a && (reason_next == dfsm_pkg::REASON_NONE);
        stopped_next = !armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            prev_active_reg <= 1'b0;
            latch_reg       <= 1'b0;
            run_reg         <= 2'b00;
        end
        else if (advance)
        begin
            armed_reg       <= armed_next;
            prev_active_reg <= s2_reg.active;
            latch_reg       <= latch_next;
            run_reg         <= run_next;
        end
    end

    // Timer start stamps are gated by the running bits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            start_reg[0] <= start_next[0];
            start_reg[1] <= start_next[1];
        end
    end

    // Result register
    logic              stopped_reg;
    logic              trip_reg;
    dfsm_pkg::reason_t reason_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stopped_reg <= stopped_next;
            trip_reg    <= (reason_next != dfsm_pkg::REASON_NONE);
            reason_reg  <= reason_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign stopped   = stopped_reg;
    assign trip      = trip_reg;
    assign reason    = reason_reg;

endmodule

// ----- verif/drive_fault_stall_monitor_top_tb.sv -----
// Testbench for the drive fault stall monitor: predicts each status item and checks it.
`timescale 1ns / 1ps

module drive_fault_stall_monitor_top_tb;

    // One sensor sample as sent on the input channel
    typedef struct {
        logic                                active;
        logic                                press;
        logic                                ctrl_off;
        logic                                enc_fault;
        logic                                near_front;
        logic                                near_rear;
        logic                                accel;
        logic signed [dfsm_pkg::SPEED_W-1:0] l_enc;
        logic signed [dfsm_pkg::SPEED_W-1:0] r_enc;
        logic signed [dfsm_pkg::SPEED_W-1:0] l_cmd;
        logic signed [dfsm_pkg::SPEED_W-1:0] r_cmd;
        logic [dfsm_pkg::TIME_W-1:0]         stamp;
    } sample_t;

    // One status item as returned on the output channel
    typedef struct {
        logic              stopped;
        logic              trip;
        dfsm_pkg::reason_t why;
    } status_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [dfsm_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [dfsm_pkg::CFG_W-1:0]          cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic                                drive_active;
    logic                                button_press;
    logic                                ctrl_disabled;
    logic                                encoder_error;
    logic                                front_obstacle;
    logic                                rear_obstacle;
    logic                                accel_alert;
    logic signed [dfsm_pkg::SPEED_W-1:0] left_enc_speed;
    logic signed [dfsm_pkg::SPEED_W-1:0] right_enc_speed;
    logic signed [dfsm_pkg::SPEED_W-1:0] left_cmd_speed;
    logic signed [dfsm_pkg::SPEED_W-1:0] right_cmd_speed;
    logic [dfsm_pkg::TIME_W-1:0]         now_us;
    logic                                out_valid;
    logic                                out_ready;
    logic                                stopped;
    logic                                trip;
    logic [2:0]                          reason;

    // Monitor state as predicted
    logic                          mon_armed;
    logic                          mon_prev_active;
    logic                          mon_button;
    logic                          wheel_run [2];
    logic [dfsm_pkg::TIME_W-1:0]   wheel_start [2];
    logic [dfsm_pkg::GAIN_W-1:0]   enc_gain;
    logic [dfsm_pkg::GAIN_W-1:0]   cmd_gain;
    logic [dfsm_pkg::STALL_W-1:0]  stall_limit;

    // Pending status items, oldest first
    status_t             status_q [$];
    status_t             want_status;
    int                  mismatches;

    // Handshake shaping
    int                            gap_max;
    int                            stall_max;
    int                            hold_request;
    logic [dfsm_pkg::TIME_W-1:0]   sim_us;

    // Register settings swept by the random phases
    logic [dfsm_pkg::GAIN_W-1:0]  enc_gain_set [6] = '{16'd256, 16'd0, 16'd65535, 16'd1,
                                                       16'd65535, 16'd300};
    logic [dfsm_pkg::GAIN_W-1:0]  cmd_gain_set [6] = '{16'd256, 16'd0, 16'd65535, 16'd65535,
                                                       16'd1, 16'd200};
    logic [dfsm_pkg::STALL_W-1:0] stall_set [6] = '{24'd1000000, 24'd0, 24'd16777215, 24'd1000,
                                                    24'd50, 24'd5000};

    drive_fault_stall_monitor_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .drive_active    (drive_active),
        .button_press    (button_press),
        .ctrl_disabled   (ctrl_disabled),
        .encoder_error   (encoder_error),
        .front_obstacle  (front_obstacle),
        .rear_obstacle   (rear_obstacle),
        .accel_alert     (accel_alert),
        .left_enc_speed  (left_enc_speed),
        .right_enc_speed (right_enc_speed),
        .left_cmd_speed  (left_cmd_speed),
        .right_cmd_speed (right_cmd_speed),
        .now_us          (now_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stopped         (stopped),
        .trip            (trip),
        .reason          (reason)
    );

    always #10 clk = ~clk;

    // Stall timers and button latch cleared
    function automatic void drop_watch();
        mon_button = 1'b0;
        wheel_run[0] = 1'b0;
        wheel_run[1] = 1'b0;
        wheel_start[0] = '0;
        wheel_start[1] = '0;
    endfunction

    // Scaled encoder below half the scaled command, on the command's side of zero
    function automatic logic wheel_lagging(logic signed [dfsm_pkg::SPEED_W-1:0] spd,
                                           logic signed [dfsm_pkg::SPEED_W-1:0] cmd);
        longint e;
        longint c;
        e = longint'(spd) * longint'(enc_gain) * 2;
        c = longint'(cmd) * longint'(cmd_gain);
        return (c >= 0) ? (e < c) : (e > c);
    endfunction

    // Advance one wheel timer; true once it has lagged longer than the stall time
    function automatic logic wheel_overdue(int w, logic signed [dfsm_pkg::SPEED_W-1:0] spd,
                                           logic signed [dfsm_pkg::SPEED_W-1:0] cmd,
                                           logic [dfsm_pkg::TIME_W-1:0] stamp);
        logic [dfsm_pkg::TIME_W-1:0] elapsed;
        if (wheel_lagging(spd, cmd))
        begin
            if (!wheel_run[w])
            begin
                wheel_run[w] = 1'b1;
                wheel_start[w] = stamp;
            end
        end
        else
            wheel_run[w] = 1'b0;
        elapsed = stamp - wheel_start[w];
        return wheel_run[w] && (elapsed > dfsm_pkg::TIME_W'(stall_limit));
    endfunction

    // Status produced by one accepted sample
    function automatic status_t predict_status(sample_t s);
        status_t r;
        dfsm_pkg::reason_t why;
        why = dfsm_pkg::REASON_NONE;
        if (!s.active)
            mon_armed = 1'b0;
        else if (!mon_prev_active)
            mon_armed = 1'b1;
        mon_prev_active = s.active;
        if (!mon_armed)
        begin
            drop_watch();
            r.stopped = 1'b1;
            r.trip = 1'b0;
            r.why = dfsm_pkg::REASON_NONE;
            return r;
        end
        if (s.press)
            mon_button = 1'b1;
        // Checks in priority order, the stall timers only when reached
        if (s.ctrl_off)
            why = dfsm_pkg::REASON_CTRL;
        else if (mon_button)
            why = dfsm_pkg::REASON_BUTTON;
        else if (s.enc_fault)
            why = dfsm_pkg::REASON_ENCODER;
        else if (s.near_front || s.near_rear)
            why = dfsm_pkg::REASON_PROX;
        else if (s.accel)
            why = dfsm_pkg::REASON_ACCEL;
        else if (wheel_overdue(0, s.l_enc, s.l_cmd, s.stamp))
            why = dfsm_pkg::REASON_LSTALL;
        else if (wheel_overdue(1, s.r_enc, s.r_cmd, s.stamp))
            why = dfsm_pkg::REASON_RSTALL;
        if (why != dfsm_pkg::REASON_NONE)
        begin
            mon_armed = 1'b0;
            drop_watch();
        end
        r.stopped = !mon_armed;
        r.trip = (why != dfsm_pkg::REASON_NONE);
        r.why = why;
        return r;
    endfunction

    function automatic sample_t calm_sample(logic active, logic [dfsm_pkg::TIME_W-1:0] stamp);
        sample_t s;
        s = '{default: '0};
        s.active = active;
        s.stamp = stamp;
        return s;
    endfunction

    // Offer one item after a random gap, predict its status once accepted
    task automatic send_sample(input sample_t s);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        drive_active    <= s.active;
        button_press    <= s.press;
        ctrl_disabled   <= s.ctrl_off;
        encoder_error   <= s.enc_fault;
        front_obstacle  <= s.near_front;
        rear_obstacle   <= s.near_rear;
        accel_alert     <= s.accel;
        left_enc_speed  <= s.l_enc;
        right_enc_speed <= s.r_enc;
        left_cmd_speed  <= s.l_cmd;
        right_cmd_speed <= s.r_cmd;
        now_us          <= s.stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        status_q.push_back(predict_status(s));
    endtask

    // Stop offering and wait until every status item is back
    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dfsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dfsm_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            dfsm_pkg::CFG_ENC_GAIN:   enc_gain = val[dfsm_pkg::GAIN_W-1:0];
            dfsm_pkg::CFG_CMD_GAIN:   cmd_gain = val[dfsm_pkg::GAIN_W-1:0];
            dfsm_pkg::CFG_STALL_TIME: stall_limit = val[dfsm_pkg::STALL_W-1:0];
            default:                  ;
        endcase
        @(posedge clk);
    endtask

    // Speed pair: either fully random or close to the lag boundary
    task automatic pick_wheel(output logic signed [dfsm_pkg::SPEED_W-1:0] enc,
                              output logic signed [dfsm_pkg::SPEED_W-1:0] cmd);
        longint target;
        int mode;
        mode = $urandom_range(0, 5);
        cmd = dfsm_pkg::SPEED_W'($urandom);
        if (mode == 0)
            enc = dfsm_pkg::SPEED_W'($urandom);
        else
        begin
            if (mode == 1)
                cmd = '0;
            if (enc_gain != 0)
                target = (longint'(cmd) * longint'(cmd_gain)) / (2 * longint'(enc_gain));
            else
                target = 0;
            if (target > 32767)
                target = 32767;
            if (target < -32768)
                target = -32768;
            enc = dfsm_pkg::SPEED_W'(target + longint'($urandom_range(0, 6)) - 3);
        end
    endtask

    // Random sample of a mostly well-formed drive: rare faults, advancing time
    task automatic make_random(output sample_t s);
        int mode;
        s = calm_sample(1'b1, '0);
        if (mon_armed)
            s.active = ($urandom_range(0, 39) != 0);
        else
            s.active = 1'($urandom_range(0, 1));
        s.press      = ($urandom_range(0, 59) == 0);
        s.ctrl_off   = ($urandom_range(0, 79) == 0);
        s.enc_fault  = ($urandom_range(0, 79) == 0);
        s.near_front = ($urandom_range(0, 79) == 0);
        s.near_rear  = ($urandom_range(0, 79) == 0);
        s.accel      = ($urandom_range(0, 79) == 0);
        pick_wheel(s.l_enc, s.l_cmd);
        pick_wheel(s.r_enc, s.r_cmd);
        mode = $urandom_range(0, 59);
        if (mode == 0)
            sim_us = dfsm_pkg::TIME_W'({$urandom, $urandom});
        else if (mode == 1)
            sim_us = '1 - dfsm_pkg::TIME_W'($urandom_range(0, stall_limit));
        else
            sim_us = sim_us + dfsm_pkg::TIME_W'($urandom_range(0, stall_limit / 3 + 3));
        s.stamp = sim_us;
    endtask

    task automatic run_random(input int count);
        sample_t s;
        repeat (count)
        begin
            make_random(s);
            send_sample(s);
        end
    endtask

    // Arming, each fault flag, priority and silent disarm
    task automatic test_arming_and_flags();
        sample_t s;
        send_sample(calm_sample(1'b0, 48'd100));
        send_sample(calm_sample(1'b1, 48'd110));
        s = calm_sample(1'b1, 48'd120);
        s.ctrl_off = 1'b1;
        send_sample(s);
        // still high, no fresh rising edge: stays stopped
        send_sample(calm_sample(1'b1, 48'd130));
        send_sample(calm_sample(1'b0, 48'd140));
        // fault on the arming tick itself
        s = calm_sample(1'b1, 48'd150);
        s.enc_fault = 1'b1;
        send_sample(s);
        send_sample(calm_sample(1'b0, 48'd160));
        s = calm_sample(1'b1, 48'd170);
        s.near_front = 1'b1;
        send_sample(s);
        send_sample(calm_sample(1'b0, 48'd180));
        s = calm_sample(1'b1, 48'd190);
        s.near_rear = 1'b1;
        send_sample(s);
        send_sample(calm_sample(1'b0, 48'd200));
        s = calm_sample(1'b1, 48'd210);
        s.accel = 1'b1;
        send_sample(s);
        send_sample(calm_sample(1'b0, 48'd220));
        s = calm_sample(1'b1, 48'd230);
        {s.press, s.ctrl_off, s.enc_fault, s.near_front, s.near_rear, s.accel} = '1;
        send_sample(s);
        // drive ends while armed: no trip
        send_sample(calm_sample(1'b0, 48'd240));
        send_sample(calm_sample(1'b1, 48'd250));
        send_sample(calm_sample(1'b0, 48'd260));
        settle_outputs();
    endtask

    // Press while disarmed is dropped, press while armed trips the same tick
    task automatic test_button_latch();
        sample_t s;
        s = calm_sample(1'b0, 48'd300);
        s.press = 1'b1;
        send_sample(s);
        send_sample(calm_sample(1'b1, 48'd310));
        s = calm_sample(1'b1, 48'd320);
        s.press = 1'b1;
        send_sample(s);
        settle_outputs();
    endtask

    // Stall timers at the default setting: boundary, wrap, restart, left over right
    task automatic test_stall_timers();
        sample_t s;
        send_sample(calm_sample(1'b0, 48'd0));
        s = calm_sample(1'b1, 48'd10);
        s.l_cmd = 16'sd1000;
        send_sample(s);
        s.stamp = 48'd1000010;
        send_sample(s);
        s.stamp = 48'd1000011;
        send_sample(s);
        // extreme speeds on a negative command, timestamp wrapping
        send_sample(calm_sample(1'b0, 48'd0));
        s = calm_sample(1'b1, 48'hFFFF_FFFF_FFF0);
        s.r_cmd = 16'sh8000;
        s.r_enc = 16'sh7FFF;
        send_sample(s);
        s.stamp = 48'hFFFF_FFFF_FFF0 + 48'd1000001;
        send_sample(s);
        // lag broken off restarts the timer
        send_sample(calm_sample(1'b0, 48'd0));
        s = calm_sample(1'b1, 48'd0);
        s.l_cmd = 16'sd100;
        s.l_enc = 16'sd10;
        send_sample(s);
        s.stamp = 48'd600000;
        s.l_enc = 16'sd50;
        send_sample(s);
        s.stamp = 48'd700000;
        s.l_enc = 16'sd10;
        send_sample(s);
        s.stamp = 48'd1700001;
        send_sample(s);
        // both wheels overdue: left wins
        send_sample(calm_sample(1'b0, 48'd0));
        s = calm_sample(1'b1, 48'd5);
        s.l_enc = 16'sh8000;
        s.l_cmd = 16'sh7FFF;
        s.r_enc = 16'sh8000;
        s.r_cmd = 16'sh7FFF;
        send_sample(s);
        s.stamp = 48'd2000000;
        send_sample(s);
        settle_outputs();
    endtask

    // Random drives across register settings, extremes included
    task automatic test_register_settings();
        for (int k = 0; k < 6; k++)
        begin
            write_reg(dfsm_pkg::CFG_ENC_GAIN, {8'($urandom), enc_gain_set[k]});
            write_reg(dfsm_pkg::CFG_CMD_GAIN, {8'($urandom), cmd_gain_set[k]});
            write_reg(dfsm_pkg::CFG_STALL_TIME, stall_set[k]);
            // every third phase runs without any idling
            gap_max = (k % 3 == 2) ? 0 : 6;
            stall_max = (k % 3 == 2) ? 0 : 6;
            run_random(230);
            settle_outputs();
        end
        gap_max = 6;
        stall_max = 6;
    endtask

    // Receiver holds off long enough for the pipeline to fill and refuse input
    task automatic test_output_backpressure();
        gap_max = 0;
        hold_request = 80;
        run_random(50);
        settle_outputs();
        gap_max = 6;
    endtask

    // Sender pauses mid-drive until every result is back
    task automatic test_sender_pause();
        run_random(40);
        settle_outputs();
        run_random(40);
        settle_outputs();
    endtask

    // Receiver: random stall per item, or a long hold when asked
    initial
    begin
        int n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
            end
            else
                n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare each accepted status item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected item stopped=%0b trip=%0b reason=%0d",
                             stopped, trip, reason);
            end
            else
            begin
                want_status = status_q.pop_front();
                if (stopped !== want_status.stopped || trip !== want_status.trip ||
                    reason !== want_status.why)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: stopped/trip/reason exp %0b/%0b/%0d act %0b/%0b/%0d",
                                 want_status.stopped, want_status.trip, want_status.why,
                                 stopped, trip, reason);
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = dfsm_pkg::CFG_ENC_GAIN;
        cfg_data        = '0;
        in_valid        = 1'b0;
        drive_active    = 1'b0;
        button_press    = 1'b0;
        ctrl_disabled   = 1'b0;
        encoder_error   = 1'b0;
        front_obstacle  = 1'b0;
        rear_obstacle   = 1'b0;
        accel_alert     = 1'b0;
        left_enc_speed  = '0;
        right_enc_speed = '0;
        left_cmd_speed  = '0;
        right_cmd_speed = '0;
        now_us          = '0;
        mon_armed       = 1'b0;
        mon_prev_active = 1'b0;
        drop_watch();
        enc_gain        = dfsm_pkg::ENC_GAIN_RST;
        cmd_gain        = dfsm_pkg::CMD_GAIN_RST;
        stall_limit     = dfsm_pkg::STALL_TIME_RST;
        mismatches      = 0;
        gap_max         = 6;
        stall_max       = 6;
        hold_request    = 0;
        sim_us          = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arming_and_flags();
        test_button_latch();
        test_stall_timers();
        test_output_backpressure();
        test_sender_pause();
        test_register_settings();

        settle_outputs();
        if (mismatches == 0 && status_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
